>>> rtl/sprt_pkg.sv
// ----------------------------------------------------------------------------
// sprt_pkg
// Shared types and constants of the page frame reference count table.
// ----------------------------------------------------------------------------
package sprt_pkg;

    localparam int TABLE_ENTRIES = 1024;
    // bucket count is a power of two, the bucket is the low frame bits
    localparam int HASH_BUCKETS  = 128;
    localparam int FRAME_BITS    = 20;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int LINK_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int BKT_W   = $clog2(HASH_BUCKETS);
    localparam int CMD_W   = 2;
    localparam int PAGE_W  = 20;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 16;

    localparam logic [LINK_W-1:0]  NIL_LINK  = LINK_W'(TABLE_ENTRIES);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_SHARE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNSHARE = 2'd1;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_SATURATED = 2'd3;

    typedef struct packed {
        logic                  valid;
        logic [FRAME_BITS-1:0] frame;
        logic [COUNT_W-1:0]    count;
        logic [LINK_W-1:0]     link;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

>>> rtl/sprt_ifs.sv
// ----------------------------------------------------------------------------
// sprt request and response channels
// Valid/ready channels carrying one command word and one result word.
// ----------------------------------------------------------------------------
interface sprt_req_if import sprt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [PAGE_W-1:0] page_number;
    modport source (output valid, cmd, page_number, input ready);
    modport sink   (input valid, cmd, page_number, output ready);
endinterface

interface sprt_rsp_if import sprt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] ref_count;
    logic               is_shared;
    modport source (output valid, status, ref_count, is_shared, input ready);
    modport sink   (input valid, status, ref_count, is_shared, output ready);
endinterface

>>> rtl/shared_page_refcount_table_unit.sv
// ----------------------------------------------------------------------------
// shared_page_refcount_table_unit
// Reference counts of shared page frames in a hashed, chained entry table.
// ----------------------------------------------------------------------------
// One command at a time. After reset the entry RAM is cleared, all
// TABLE_ENTRIES (1024) entries, before the first command is taken. A command
// reads the bucket head, then each chain entry visited on the entry RAM read port;
// a share of a new frame also reads each entry the allocation pointer scans,
// up to all TABLE_ENTRIES entries when the table is full, and an append or unlink
// behind the chain head adds a write of the previous entry. A finished result sits
// in the output register while the next command is accepted.
module shared_page_refcount_table_unit import sprt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sprt_req_if.sink        i_req,
    sprt_rsp_if.source      o_rsp
);

    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_HEAD     = 4'd2;
    localparam logic [3:0] S_WALK     = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CHK = 4'd5;
    localparam logic [3:0] S_WR2      = 4'd6;
    localparam logic [3:0] S_RESP     = 4'd7;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [3:0]              r_state, n_state;
    logic [IDX_W-1:0]        r_clr_idx, n_clr_idx;
    logic [CMD_W-1:0]        r_cmd, n_cmd;
    logic [FRAME_BITS-1:0]   r_frame, n_frame;
    logic [HASH_BUCKETS-1:0] r_bkt_v, n_bkt_v;
    logic [LINK_W-1:0]       r_p, n_p;
    logic [IDX_W-1:0]        r_prev_idx, n_prev_idx;
    t_entry                  r_prev_word, n_prev_word;
    logic                    r_have_prev, n_have_prev;
    logic [IDX_W-1:0]        r_scan, n_scan;
    logic [IDX_W-1:0]        r_scan_cnt, n_scan_cnt;
    logic [IDX_W-1:0]        r_alloc, n_alloc;
    logic [IDX_W-1:0]        r_wr2_addr, n_wr2_addr;
    t_entry                  r_wr2_word, n_wr2_word;
    logic [STAT_W-1:0]       r_status, n_status;
    logic [COUNT_W-1:0]      r_count, n_count;
    logic                    r_shared, n_shared;
    logic                    r_out_valid, n_out_valid;
    logic [STAT_W-1:0]       r_out_status, n_out_status;
    logic [COUNT_W-1:0]      r_out_count, n_out_count;
    logic                    r_out_shared, n_out_shared;

    logic                    ent_we;
    logic [IDX_W-1:0]        ent_waddr;
    t_entry                  ent_wdata;
    logic [IDX_W-1:0]        ent_raddr;
    logic [ENTRY_W-1:0]      ent_rbits;
    t_entry                  ent_rdata;
    logic                    bkt_we;
    logic [BKT_W-1:0]        bkt_waddr;
    logic [LINK_W-1:0]       bkt_wdata;
    logic [BKT_W-1:0]        bkt_raddr;
    logic [LINK_W-1:0]       bkt_rdata;
    logic [BKT_W-1:0]        cur_bkt;
    logic [LINK_W-1:0]       head;
    t_entry                  clear_word;

    assign ent_rdata = t_entry'(ent_rbits);
    assign cur_bkt   = r_frame[BKT_W-1:0];
    assign head      = r_bkt_v[cur_bkt] ? bkt_rdata : NIL_LINK;
    assign clear_word = '{valid: 1'b0, frame: '0, count: '0, link: NIL_LINK};

    sprt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES), .ADDR_W(IDX_W)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ENTRY_W'(ent_wdata)),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rbits)
    );

    sprt_ram #(.WIDTH(LINK_W), .DEPTH(HASH_BUCKETS), .ADDR_W(BKT_W)) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (bkt_we),
        .i_waddr (bkt_waddr),
        .i_wdata (bkt_wdata),
        .i_raddr (bkt_raddr),
        .o_rdata (bkt_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_cmd        = r_cmd;
        n_frame      = r_frame;
        n_bkt_v      = r_bkt_v;
        n_p          = r_p;
        n_prev_idx   = r_prev_idx;
        n_prev_word  = r_prev_word;
        n_have_prev  = r_have_prev;
        n_scan       = r_scan;
        n_scan_cnt   = r_scan_cnt;
        n_alloc      = r_alloc;
        n_wr2_addr   = r_wr2_addr;
        n_wr2_word   = r_wr2_word;
        n_status     = r_status;
        n_count      = r_count;
        n_shared     = r_shared;
        n_out_valid  = r_out_valid & ~o_rsp.ready;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_shared = r_out_shared;
        ent_we       = 1'b0;
        ent_waddr    = r_p[IDX_W-1:0];
        ent_wdata    = ent_rdata;
        ent_raddr    = r_p[IDX_W-1:0];
        bkt_we       = 1'b0;
        bkt_waddr    = cur_bkt;
        bkt_wdata    = NIL_LINK;
        bkt_raddr    = cur_bkt;

        case (r_state)
            S_CLR: begin
                ent_we    = 1'b1;
                ent_waddr = r_clr_idx;
                ent_wdata = clear_word;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                bkt_raddr = i_req.page_number[BKT_W-1:0];
                if (i_req.valid) begin
                    n_cmd       = i_req.cmd;
                    n_frame     = FRAME_BITS'(i_req.page_number);
                    n_have_prev = 1'b0;
                    n_state     = S_HEAD;
                end
            end
            S_HEAD, S_WALK: begin
                logic miss;
                miss = 1'b0;
                if (r_state == S_HEAD) begin
                    if (head[LINK_W-1]) begin
                        miss = 1'b1;
                    end else begin
                        n_p       = head;
                        ent_raddr = head[IDX_W-1:0];
                        n_state   = S_WALK;
                    end
                end else if (ent_rdata.valid && ent_rdata.frame == r_frame) begin
                    // hit
                    n_state  = S_RESP;
                    n_status = ST_OK;
                    n_count  = ent_rdata.count;
                    n_shared = 1'b1;
                    case (r_cmd)
                        CMD_SHARE: begin
                            if (ent_rdata.count == COUNT_MAX) begin
                                n_status = ST_SATURATED;
                            end else begin
                                ent_we          = 1'b1;
                                ent_wdata.count = ent_rdata.count + 1'b1;
                                n_count         = ent_rdata.count + 1'b1;
                            end
                        end
                        CMD_UNSHARE: begin
                            ent_we = 1'b1;
                            if (ent_rdata.count <= COUNT_W'(1)) begin
                                ent_wdata = clear_word;
                                n_count   = '0;
                                n_shared  = 1'b0;
                                if (r_have_prev) begin
                                    n_wr2_addr      = r_prev_idx;
                                    n_wr2_word      = r_prev_word;
                                    n_wr2_word.link = ent_rdata.link;
                                    n_state         = S_WR2;
                                end else begin
                                    bkt_we    = 1'b1;
                                    bkt_wdata = ent_rdata.link;
                                end
                            end else begin
                                ent_wdata.count = ent_rdata.count - 1'b1;
                                n_count         = ent_rdata.count - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    n_prev_idx  = r_p[IDX_W-1:0];
                    n_prev_word = ent_rdata;
                    n_have_prev = 1'b1;
                    if (ent_rdata.link[LINK_W-1]) begin
                        miss = 1'b1;
                    end else begin
                        n_p       = ent_rdata.link;
                        ent_raddr = ent_rdata.link[IDX_W-1:0];
                    end
                end
                if (miss) begin
                    if (r_cmd == CMD_SHARE) begin
                        n_scan     = r_alloc;
                        n_scan_cnt = '0;
                        n_state    = S_SCAN_RD;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_count  = '0;
                        n_shared = 1'b0;
                        n_state  = S_RESP;
                    end
                end
            end
            S_SCAN_RD: begin
                ent_raddr = r_scan;
                n_state   = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (!ent_rdata.valid) begin
                    n_alloc   = r_scan;
                    ent_we    = 1'b1;
                    ent_waddr = r_scan;
                    ent_wdata = '{valid: 1'b1, frame: r_frame, count: COUNT_W'(1),
                                  link: NIL_LINK};
                    n_status  = ST_OK;
                    n_count   = COUNT_W'(1);
                    n_shared  = 1'b1;
                    n_state   = S_RESP;
                    if (r_have_prev) begin
                        n_wr2_addr      = r_prev_idx;
                        n_wr2_word      = r_prev_word;
                        n_wr2_word.link = LINK_W'(r_scan);
                        n_state         = S_WR2;
                    end else begin
                        bkt_we           = 1'b1;
                        bkt_wdata        = LINK_W'(r_scan);
                        n_bkt_v[cur_bkt] = 1'b1;
                    end
                end else if (r_scan_cnt == LAST_IDX) begin
                    n_status = ST_FULL;
                    n_count  = '0;
                    n_shared = 1'b0;
                    n_state  = S_RESP;
                end else begin
                    n_scan     = (r_scan == LAST_IDX) ? '0 : r_scan + 1'b1;
                    n_scan_cnt = r_scan_cnt + 1'b1;
                    n_state    = S_SCAN_RD;
                end
            end
            S_WR2: begin
                ent_we    = 1'b1;
                ent_waddr = r_wr2_addr;
                ent_wdata = r_wr2_word;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = r_count;
                    n_out_shared = r_shared;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_idx   <= '0;
            r_bkt_v     <= '0;
            r_alloc     <= '0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_bkt_v     <= n_bkt_v;
            r_alloc     <= n_alloc;
            r_have_prev <= n_have_prev;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_frame      <= n_frame;
        r_p          <= n_p;
        r_prev_idx   <= n_prev_idx;
        r_prev_word  <= n_prev_word;
        r_scan       <= n_scan;
        r_scan_cnt   <= n_scan_cnt;
        r_wr2_addr   <= n_wr2_addr;
        r_wr2_word   <= n_wr2_word;
        r_status     <= n_status;
        r_count      <= n_count;
        r_shared     <= n_shared;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_shared <= n_out_shared;
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.ref_count = r_out_count;
    assign o_rsp.is_shared = r_out_shared;

endmodule

>>> rtl/sprt_ram.sv
// ----------------------------------------------------------------------------
// sprt_ram
// Simple dual port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sprt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sprt_checker.sv
// ----------------------------------------------------------------------------
// sprt_checker
// Port level checks on the result channel of the reference count table.
// ----------------------------------------------------------------------------
module sprt_checker import sprt_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [STAT_W-1:0]  i_status,
    input logic [COUNT_W-1:0] i_ref_count,
    input logic               i_is_shared
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result word dropped while stalled");

    a_shared_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_is_shared == (i_ref_count != '0)))
        else $error("is_shared disagrees with ref_count");

    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_NOT_FOUND || i_status == ST_FULL) |-> !i_is_shared)
        else $error("missing frame reported as present");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_SATURATED |-> i_ref_count == COUNT_MAX)
        else $error("saturated status below maximum count");

endmodule

bind shared_page_refcount_table_unit sprt_checker u_sprt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_rsp.valid),
    .i_ready     (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_ref_count (o_rsp.ref_count),
    .i_is_shared (o_rsp.is_shared)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench for shared_page_refcount_table_unit
// Drives share, unshare, query and unused command words at the request channel and
// predicts every result word from a private copy of the entry table. The run covers
// directed corner cases, random traffic under several idling phases, and a
// completely filled table.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sprt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 4000;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] ref_count;
        logic               is_shared;
    } t_result;

    class refcount_scoreboard;
        bit                 used [TABLE_ENTRIES];
        logic [PAGE_W-1:0]  frame_of [TABLE_ENTRIES];
        logic [COUNT_W-1:0] count_of [TABLE_ENTRIES];
        int                 slot_of [int];
        int                 alloc_ptr;
        int                 live;
        int                 errors;
        t_result            expected_q [$];

        function new();
            alloc_ptr = 0;
            live = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit present(logic [PAGE_W-1:0] page);
            return slot_of.exists(int'(page));
        endfunction

        function logic [PAGE_W-1:0] any_present();
            int s;
            s = $urandom_range(TABLE_ENTRIES - 1);
            while (!used[s]) s = (s + 1) % TABLE_ENTRIES;
            return frame_of[s];
        endfunction

        function void note(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] page);
            t_result r;
            int s;
            int p;
            bit hit;
            r = '{ST_OK, '0, 1'b0};
            hit = slot_of.exists(int'(page));
            s = hit ? slot_of[int'(page)] : -1;
            if (cmd == CMD_SHARE) begin
                if (hit) begin
                    if (count_of[s] == COUNT_MAX) r.status = ST_SATURATED;
                    else count_of[s] = count_of[s] + 1'b1;
                    r.ref_count = count_of[s];
                    r.is_shared = 1'b1;
                end else if (live == TABLE_ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    p = alloc_ptr;
                    while (used[p]) p = (p + 1) % TABLE_ENTRIES;
                    alloc_ptr = p;
                    used[p] = 1'b1;
                    frame_of[p] = page;
                    count_of[p] = 1;
                    slot_of[int'(page)] = p;
                    live++;
                    r.ref_count = 1;
                    r.is_shared = 1'b1;
                end
            end else if (cmd == CMD_UNSHARE) begin
                if (!hit) begin
                    r.status = ST_NOT_FOUND;
                end else if (count_of[s] <= 1) begin
                    used[s] = 1'b0;
                    slot_of.delete(int'(page));
                    live--;
                end else begin
                    count_of[s] = count_of[s] - 1'b1;
                    r.ref_count = count_of[s];
                    r.is_shared = 1'b1;
                end
            end else begin
                if (hit) begin
                    r.ref_count = count_of[s];
                    r.is_shared = 1'b1;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check(t_result got);
            t_result exp;
            if (expected_q.size() == 0) begin
                $error("result word with no expectation: status %0d count %0d shared %0d",
                       got.status, got.ref_count, got.is_shared);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.ref_count !== exp.ref_count) begin
                $error("ref_count: expected %0d, actual %0d", exp.ref_count, got.ref_count);
                errors++;
            end
            if (got.is_shared !== exp.is_shared) begin
                $error("is_shared: expected %0d, actual %0d", exp.is_shared, got.is_shared);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   idle_mode = 0;
    int   quiet_cycles = 0;
    refcount_scoreboard sb = new();

    sprt_req_if req ();
    sprt_rsp_if rsp ();

    shared_page_refcount_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        req.valid = 1'b0;
        req.cmd = '0;
        req.page_number = '0;
        rsp.ready = 1'b0;
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (idle_mode == 2) rsp.ready = ($urandom_range(99) >= 46);
        else if (idle_mode == 3) rsp.ready = ($urandom_range(99) >= 13);
        else rsp.ready = 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready)
            sb.check('{rsp.status, rsp.ref_count, rsp.is_shared});
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] page);
        bit gap;
        gap = (idle_mode == 1 && $urandom_range(99) < 46) ||
              (idle_mode == 3 && $urandom_range(99) < 13);
        while (gap) begin
            req.valid = 1'b0;
            @(negedge i_clk);
            gap = (idle_mode == 1 && $urandom_range(99) < 46) ||
                  (idle_mode == 3 && $urandom_range(99) < 13);
        end
        req.valid = 1'b1;
        req.cmd = cmd;
        req.page_number = page;
        do @(posedge i_clk); while (!req.ready);
        sb.note(cmd, page);
        @(negedge i_clk);
        req.valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [PAGE_W-1:0] pick_frame();
        int r;
        r = $urandom_range(99);
        if (r < 60) return PAGE_W'({$urandom_range(7), 5'd0, 2'($urandom_range(3))});
        if (r < 80 && sb.live > 0) return sb.any_present();
        return PAGE_W'($urandom);
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 45) return CMD_SHARE;
        if (r < 80) return CMD_UNSHARE;
        if (r < 95) return CMD_QUERY;
        return CMD_UNUSED;
    endfunction

    function automatic logic [PAGE_W-1:0] fresh_frame();
        logic [PAGE_W-1:0] f;
        f = PAGE_W'($urandom);
        while (sb.present(f)) f = PAGE_W'($urandom);
        return f;
    endfunction

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners
        send(CMD_QUERY, '0);
        send(CMD_UNSHARE, '0);
        send(CMD_SHARE, '0);
        send(CMD_SHARE, '0);
        send(CMD_QUERY, '0);
        send(CMD_UNUSED, '0);
        send(CMD_SHARE, '1);
        send(CMD_QUERY, '1);
        send(CMD_UNUSED, '1);
        // one bucket, four deep with frame zero, unlink head, middle and tail
        send(CMD_SHARE, 20'h00080);
        send(CMD_SHARE, 20'h00100);
        send(CMD_SHARE, 20'hFFF80);
        send(CMD_UNSHARE, 20'h00100);
        send(CMD_QUERY, 20'hFFF80);
        send(CMD_UNSHARE, '0);
        send(CMD_UNSHARE, '0);
        send(CMD_QUERY, '0);
        send(CMD_QUERY, 20'h00080);
        send(CMD_UNSHARE, 20'hFFF80);
        send(CMD_UNSHARE, 20'h00080);
        send(CMD_UNSHARE, '1);
        send(CMD_QUERY, '1);
        send(CMD_SHARE, 20'h00100);
        send(CMD_QUERY, 20'h00100);
        drain();

        for (int m = 0; m < 4; m++) begin
            idle_mode = m;
            repeat (100) send(pick_cmd(), pick_frame());
        end

        // hold off until everything is back, then fill the table
        idle_mode = 0;
        drain();
        while (sb.live < TABLE_ENTRIES) send(CMD_SHARE, fresh_frame());
        idle_mode = 3;
        repeat (5) send(CMD_SHARE, fresh_frame());
        repeat (100) begin
            if ($urandom_range(1)) send(pick_cmd(), sb.any_present());
            else send(pick_cmd(), fresh_frame());
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
